// ===== sv/ipv6lpm_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv6lpm_pkg
// Shared constants, request codes and default parameters for the IPv6
// longest-prefix-match lookup block.
// ----------------------------------------------------------------------------
package ipv6lpm_pkg;

    // Default table geometry
    localparam int ROOT_STRIDE_DEF   = 16;
    localparam int SUB_STRIDE_DEF    = 8;
    localparam int NUM_SUBTABLES_DEF = 4096;
    localparam int HOP_BITS_DEF      = 16;

    // Fixed field widths of the request and result
    localparam int ADDR_W     = 128;
    localparam int HALF_W     = 64;
    localparam int SLOT_W     = 20;
    localparam int WR_HOP_W   = 16;
    localparam int CHILD_W    = 12;
    localparam int REQ_W      = 2;
    localparam int HOP_OUT_W  = 16;
    localparam int LVL_OUT_W  = 4;
    localparam int S_TDATA_W  = 184;
    localparam int M_TDATA_W  = 24;

    // Request kinds carried on s_tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP  = 2'd0,
        REQ_WR_ROOT = 2'd1,
        REQ_WR_SUB  = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

endpackage

// ===== sv/ipv6lpm_ram.sv =====
// ----------------------------------------------------------------------------
// ipv6lpm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ipv6lpm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ipv6_multilevel_lpm_lookup.sv =====
// ----------------------------------------------------------------------------
// ipv6_multilevel_lpm_lookup
// Longest-prefix-match lookup of a 128-bit IPv6 address in a direct-indexed
// multilevel table (root table plus 2^SUB_STRIDE-entry subtables).
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on s_tvalid/s_tready/s_tdata with the request kind on
//   s_tuser: lookup, write root entry, write subtable entry. Every request
//   gives exactly one result on m_tvalid/m_tready/m_tdata, with m_tuser set
//   for a write acknowledge.
//   A lookup reads the root table, then one subtable per level, one table
//   read per cycle through a single shared address shifter. A walk reads
//   at most 15 levels at the default strides. Writes and unknown requests
//   skip the walk and go straight to the response state. s_tready is
//   high only while the sequencer is idle, so one request is in flight.
//   A finished result sits in the output register; the next request is
//   taken while it waits. If the receiver stalls and a further result is
//   ready, the sequencer holds it until the output register is taken.
//   After reset both tables are cleared by a pass over
//   max(2^ROOT_STRIDE, NUM_SUBTABLES * 2^SUB_STRIDE) entries (1048576 at the
//   defaults), one entry of each table per cycle; s_tready stays low.
// ----------------------------------------------------------------------------
module ipv6_multilevel_lpm_lookup
    import ipv6lpm_pkg::*;
#(
    parameter int ROOT_STRIDE   = ROOT_STRIDE_DEF,
    parameter int SUB_STRIDE    = SUB_STRIDE_DEF,
    parameter int NUM_SUBTABLES = NUM_SUBTABLES_DEF,
    parameter int HOP_BITS      = HOP_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: addr_high[63:0], addr_low[127:64], slot_index[147:128],
    //          wr_valid[148], wr_hop[164:149], wr_has_child[165],
    //          wr_child[177:166], zero pad[183:178]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [REQ_W-1:0]     s_tuser,
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: found_hop[15:0], levels_used[19:16], zero pad[23:20]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: is_write_ack[0]
    output logic                 m_tuser
);

    // Geometry
    localparam int HOP_W      = (HOP_BITS < WR_HOP_W) ? HOP_BITS : WR_HOP_W;
    localparam int ENT_W      = HOP_W + CHILD_W + 2;
    localparam int ROOT_DEPTH = 1 << ROOT_STRIDE;
    localparam int SUB_DEPTH  = NUM_SUBTABLES << SUB_STRIDE;
    localparam int RA_W       = ROOT_STRIDE;
    localparam int SA_W       = $clog2(SUB_DEPTH);
    localparam int CLR_DEPTH  = (ROOT_DEPTH > SUB_DEPTH) ? ROOT_DEPTH : SUB_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam int REM_W      = $clog2(ADDR_W + 1);
    localparam int SH_W       = $clog2(SUB_STRIDE + 1);
    localparam int MAX_LEVELS = 1 + (ADDR_W - ROOT_STRIDE + SUB_STRIDE - 1) / SUB_STRIDE;
    localparam int LVL_W      = $clog2(MAX_LEVELS + 1);

    // Entry layout: valid, has_child, child, hop from the lowest bit up
    localparam int E_VALID = 0;
    localparam int E_CHILD = 1;
    localparam int E_CNUM  = 2;
    localparam int E_HOP   = 2 + CHILD_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEVEL,
        ST_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [CLR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [HOP_W-1:0]       best_reg, best_next;
    logic                   from_root_reg, from_root_next;
    logic [HOP_OUT_W-1:0]   res_hop_reg, res_hop_next;
    logic [LVL_OUT_W-1:0]   res_lvl_reg, res_lvl_next;
    logic                   res_ack_reg, res_ack_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    // Request fields
    req_t                   req;
    logic [SLOT_W-1:0]      slot;
    logic [ENT_W-1:0]       wr_ent;
    logic [31:0]            slot32;
    logic [31:0]            clr32;

    // Table ports
    logic                   root_we, sub_we, root_re, sub_re;
    logic [RA_W-1:0]        root_waddr, root_raddr;
    logic [SA_W-1:0]        sub_waddr, sub_raddr;
    logic [ENT_W-1:0]       root_wdata, sub_wdata;
    logic [ENT_W-1:0]       root_rdata, sub_rdata;

    // Walk datapath
    logic [ENT_W-1:0]       ent;
    logic [CHILD_W-1:0]     ent_child;
    logic [SUB_STRIDE-1:0]  top_bits, idx_bits;
    logic [SH_W-1:0]        idx_sh;
    logic                   rem_short;
    logic [REM_W-1:0]       step_w;
    logic [31:0]            sub_addr32;
    logic [31:0]            lvl32;
    logic [31:0]            lvl_out32;
    logic                   walk_stop;

    assign req    = req_t'(s_tuser);
    assign slot   = s_tdata[147:128];
    assign slot32 = 32'(slot);
    assign clr32  = 32'(clr_cnt_reg);
    assign wr_ent = {s_tdata[149 +: HOP_W], s_tdata[177:166], s_tdata[165], s_tdata[148]};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Entry just read and the next subtable index from the address shifter
    assign ent       = from_root_reg ? root_rdata : sub_rdata;
    assign ent_child = ent[E_CNUM +: CHILD_W];
    assign top_bits  = addr_reg[ADDR_W-1 -: SUB_STRIDE];
    assign rem_short = (rem_reg < REM_W'(SUB_STRIDE));
    assign idx_sh    = rem_short ? SH_W'(REM_W'(SUB_STRIDE) - rem_reg) : '0;
    assign idx_bits  = top_bits >> idx_sh;
    assign step_w    = rem_short ? rem_reg : REM_W'(SUB_STRIDE);
    assign sub_addr32 = (32'(ent_child) << SUB_STRIDE) + 32'(idx_bits);
    assign walk_stop = !ent[E_CHILD] || (rem_reg == '0)
                       || (32'(ent_child) >= 32'(NUM_SUBTABLES));
    assign lvl32     = 32'(lvl_reg);
    assign lvl_out32 = 32'(res_lvl_reg);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        lvl_next       = lvl_reg;
        best_next      = best_reg;
        from_root_next = from_root_reg;
        res_hop_next   = res_hop_reg;
        res_lvl_next   = res_lvl_reg;
        res_ack_next   = res_ack_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        root_we    = 1'b0;
        sub_we     = 1'b0;
        root_re    = 1'b0;
        sub_re     = 1'b0;
        root_waddr = slot32[RA_W-1:0];
        sub_waddr  = slot32[SA_W-1:0];
        root_wdata = wr_ent;
        sub_wdata  = wr_ent;
        root_raddr = s_tdata[HALF_W-1 -: ROOT_STRIDE];
        sub_raddr  = sub_addr32[SA_W-1:0];

        // Output register drains when taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                root_we    = (clr32 < 32'(ROOT_DEPTH));
                sub_we     = (clr32 < 32'(SUB_DEPTH));
                root_waddr = clr32[RA_W-1:0];
                sub_waddr  = clr32[SA_W-1:0];
                root_wdata = '0;
                sub_wdata  = '0;
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_hop_next = '0;
                    res_lvl_next = '0;
                    res_ack_next = 1'b0;
                    state_next   = ST_RESP;
                    case (req)
                        REQ_LOOKUP:
                        begin
                            root_re        = 1'b1;
                            addr_next      = {s_tdata[63:0], s_tdata[127:64]} << ROOT_STRIDE;
                            rem_next       = REM_W'(ADDR_W - ROOT_STRIDE);
                            lvl_next       = LVL_W'(1);
                            best_next      = '0;
                            from_root_next = 1'b1;
                            state_next     = ST_LEVEL;
                        end
                        REQ_WR_ROOT:
                        begin
                            root_we      = (slot32 < 32'(ROOT_DEPTH));
                            res_ack_next = 1'b1;
                        end
                        REQ_WR_SUB:
                        begin
                            sub_we       = (slot32 < 32'(SUB_DEPTH));
                            res_ack_next = 1'b1;
                        end
                        default:
                        begin
                            res_ack_next = 1'b0;
                        end
                    endcase
                end
            end

            // One table level per cycle
            ST_LEVEL:
            begin
                if (ent[E_VALID])
                begin
                    best_next = ent[E_HOP +: HOP_W];
                end
                if (walk_stop)
                begin
                    res_hop_next = ent[E_VALID] ? HOP_OUT_W'(ent[E_HOP +: HOP_W])
                                                : HOP_OUT_W'(best_reg);
                    res_lvl_next = lvl32[LVL_OUT_W-1:0];
                    res_ack_next = 1'b0;
                    state_next   = ST_RESP;
                end
                else
                begin
                    sub_re         = 1'b1;
                    from_root_next = 1'b0;
                    addr_next      = addr_reg << SUB_STRIDE;
                    rem_next       = rem_reg - step_w;
                    lvl_next       = lvl_reg + LVL_W'(1);
                end
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, lvl_out32[LVL_OUT_W-1:0], res_hop_reg};
                    m_tuser_next  = res_ack_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            addr_reg      <= '0;
            rem_reg       <= '0;
            lvl_reg       <= '0;
            best_reg      <= '0;
            from_root_reg <= 1'b0;
            res_hop_reg   <= '0;
            res_lvl_reg   <= '0;
            res_ack_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            addr_reg      <= addr_next;
            rem_reg       <= rem_next;
            lvl_reg       <= lvl_next;
            best_reg      <= best_next;
            from_root_reg <= from_root_next;
            res_hop_reg   <= res_hop_next;
            res_lvl_reg   <= res_lvl_next;
            res_ack_reg   <= res_ack_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            m_tuser_reg   <= m_tuser_next;
        end
    end

    // Root table
    ipv6lpm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ROOT_DEPTH)
    ) u_root_ram (
        .clk   (clk),
        .we    (root_we),
        .waddr (root_waddr),
        .wdata (root_wdata),
        .re    (root_re),
        .raddr (root_raddr),
        .rdata (root_rdata)
    );

    // Subtables
    ipv6lpm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SUB_DEPTH)
    ) u_sub_ram (
        .clk   (clk),
        .we    (sub_we),
        .waddr (sub_waddr),
        .wdata (sub_wdata),
        .re    (sub_re),
        .raddr (sub_raddr),
        .rdata (sub_rdata)
    );

    // Walk depth never exceeds the levels the address can feed
    a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEVEL) |-> (lvl32 <= 32'(MAX_LEVELS)))
        else $error("lookup walked beyond the deepest level");

    // No table writes while a walk is reading
    a_no_wr_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEVEL) |-> (!root_we && !sub_we))
        else $error("table write during a lookup walk");

    // A write acknowledge carries neither hop nor level count
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tuser_reg) |-> (m_tdata_reg == '0))
        else $error("write acknowledge with non-zero result");

    // A result ready with a free output register is shown next cycle
    a_resp_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("result not loaded into output register");

    // Remaining address bits only shrink during a walk
    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEVEL && state_next == ST_LEVEL) |=> (rem_reg < $past(rem_reg)))
        else $error("address bits not consumed by a level");

endmodule

// ===== tb/sv/ipv6_multilevel_lpm_lookup_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv6_multilevel_lpm_lookup_tb
// Self-checking bench for the IPv6 longest-prefix-match lookup. A shadow copy
// of the root and subtable memories is kept here, and every accepted request
// is walked against it to predict the hop, the depth and the write acknowledge.
// Directed requests cover empty tables, field extremes and a full-depth walk.
// Random traffic then builds route chains from small pools of prefixes,
// children and address bytes, so that lookups walk deep. Both sides of the
// stream stall at random, apart from one back-to-back stretch.
// ----------------------------------------------------------------------------
module ipv6_multilevel_lpm_lookup_tb;
    import ipv6lpm_pkg::*;

    localparam int ROOT_BITS   = ROOT_STRIDE_DEF;
    localparam int SUB_BITS    = SUB_STRIDE_DEF;
    localparam int ROOT_SIZE   = 1 << ROOT_BITS;
    localparam int SUB_ENTRIES = 1 << SUB_BITS;
    localparam int SUB_SIZE    = NUM_SUBTABLES_DEF * SUB_ENTRIES;
    // Run limit, with room for the clearing pass after reset and for the traffic,
    // even with every walk at full depth and both sides stalling.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 24;

    // One table entry as the walk sees it
    typedef struct packed {
        bit        valid;
        bit [15:0] hop;
        bit        has_child;
        bit [11:0] child;
    } route_entry_t;

    // One result as it leaves the block
    typedef struct packed {
        logic [15:0] hop;
        logic [3:0]  depth;
        logic        write_ack;
    } route_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Shadow tables, cleared like the block's after reset
    route_entry_t  root_shadow [ROOT_SIZE];
    route_entry_t  sub_shadow [SUB_SIZE];
    route_result_t awaited_routes [$];
    route_result_t want_route;

    logic [15:0] prefix_picks [6];
    logic [7:0]  byte_picks [4];

    bit allow_idle;
    int mismatches;
    int results_seen;
    int cycle_count;

    ipv6_multilevel_lpm_lookup u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: random back-pressure when idling is allowed
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = !(allow_idle && $urandom_range(0, 99) < 11);
        end
    end

    // Hard stop on a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] result %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    // Walk the shadow tables for one request; writes update them
    function automatic route_result_t lpm_outcome(input req_t kind,
                                                  input logic [63:0] hi,
                                                  input logic [63:0] lo,
                                                  input logic [19:0] slot,
                                                  input route_entry_t wr);
        route_result_t res = '0;
        logic [127:0]  addr = {hi, lo};
        logic [127:0]  seg;
        route_entry_t  e;
        int unsigned   rem;
        int unsigned   w;
        int unsigned   idx;
        int unsigned   depth;
        logic [15:0]   best;
        bit            done;
        case (kind)
            REQ_WR_ROOT:
            begin
                if (slot < ROOT_SIZE)
                    root_shadow[slot] = wr;
                res.write_ack = 1'b1;
            end
            REQ_WR_SUB:
            begin
                if (slot < SUB_SIZE)
                    sub_shadow[slot] = wr;
                res.write_ack = 1'b1;
            end
            REQ_LOOKUP:
            begin
                rem = ADDR_W;
                seg = (addr >> (rem - ROOT_BITS)) & ((128'd1 << ROOT_BITS) - 128'd1);
                idx = seg[31:0];
                e = root_shadow[idx];
                rem = rem - ROOT_BITS;
                depth = 1;
                best = '0;
                done = 1'b0;
                while (!done)
                begin
                    if (e.valid)
                        best = e.hop;
                    // no child, address used up, or child beyond the tables
                    if (!e.has_child || rem == 0 || e.child >= NUM_SUBTABLES_DEF)
                        done = 1'b1;
                    else
                    begin
                        w = (rem < SUB_BITS) ? rem : SUB_BITS;
                        seg = (addr >> (rem - w)) & ((128'd1 << w) - 128'd1);
                        idx = e.child * SUB_ENTRIES + seg[31:0];
                        e = sub_shadow[idx];
                        rem = rem - w;
                        depth++;
                    end
                end
                res.hop = best;
                res.depth = depth[3:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Present one request and wait for it to be taken
    task automatic send_request(input req_t kind, input logic [63:0] hi,
                                input logic [63:0] lo, input logic [19:0] slot,
                                input logic v, input logic [15:0] hop,
                                input logic hc, input logic [11:0] child);
        route_entry_t wr;
        wr = '{valid: v, hop: hop, has_child: hc, child: child};
        @(negedge clk);
        if (allow_idle && $urandom_range(0, 99) < 11)
        begin
            s_tvalid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < 40);
        end
        s_tdata  = {6'd0, child, hc, hop, v, slot, lo, hi};
        s_tuser  = kind;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        awaited_routes.insert(awaited_routes.size(),
                              lpm_outcome(kind, hi, lo, slot, wr));
    endtask

    function automatic logic [11:0] pick_child();
        int r = $urandom_range(0, 99);
        if (r < 5)
            return 12'($urandom());
        else if (r < 15)
            return 12'hFFF;
        return 12'($urandom_range(0, 7));
    endfunction

    // Address built from the prefix and byte pools so that walks go deep
    function automatic logic [127:0] pick_addr();
        logic [127:0] a;
        a[127:112] = prefix_picks[$urandom_range(0, 5)];
        for (int k = 0; k < 14; k++)
            a[111 - 8 * k -: 8] = byte_picks[$urandom_range(0, 3)];
        return a;
    endfunction

    // One random request: mostly table building and lookups, some noise
    task automatic random_request();
        int            r = $urandom_range(0, 99);
        logic [127:0]  a;
        logic [19:0]   slot;
        logic          v;
        logic          hc;
        a    = {$urandom(), $urandom(), $urandom(), $urandom()};
        slot = 20'($urandom());
        v    = ($urandom_range(0, 99) < 70);
        hc   = ($urandom_range(0, 99) < 80);
        if (r < 5)
            send_request(req_t'($urandom_range(0, 3)), a[127:64], a[63:0], slot,
                         1'($urandom()), 16'($urandom()), 1'($urandom()),
                         12'($urandom()));
        else if (r < 25)
        begin
            if ($urandom_range(0, 99) >= 5)
                slot = {4'd0, prefix_picks[$urandom_range(0, 5)]};
            send_request(REQ_WR_ROOT, a[127:64], a[63:0], slot, v, 16'($urandom()),
                         hc, pick_child());
        end
        else if (r < 55)
        begin
            if ($urandom_range(0, 99) >= 5)
                slot = {pick_child(), byte_picks[$urandom_range(0, 3)]};
            send_request(REQ_WR_SUB, a[127:64], a[63:0], slot, v, 16'($urandom()),
                         hc, pick_child());
        end
        else
        begin
            if ($urandom_range(0, 99) >= 10)
                a = pick_addr();
            send_request(REQ_LOOKUP, a[127:64], a[63:0], slot, v, 16'($urandom()),
                         hc, 12'($urandom()));
        end
    endtask

    // Lookups on cleared tables and an unknown request
    task automatic test_empty_tables();
        send_request(REQ_LOOKUP, '0, '0, '0, 1'b0, '0, 1'b0, '0);
        send_request(REQ_LOOKUP, '1, '1, '1, 1'b1, '1, 1'b1, '1);
        send_request(REQ_NONE, '1, '1, '1, 1'b1, '1, 1'b1, '1);
    endtask

    // Out-of-range root slot, all-ones entries and a self-referencing subtable
    task automatic test_field_extremes();
        send_request(REQ_WR_ROOT, '0, '0, 20'hFFFFF, 1'b1, 16'hFFFF, 1'b1, 12'hFFF);
        send_request(REQ_WR_ROOT, '0, '0, 20'h0FFFF, 1'b1, 16'hFFFF, 1'b1, 12'hFFF);
        send_request(REQ_LOOKUP, '1, '1, '0, 1'b0, '0, 1'b0, '0);
        // last subtable slot points back at itself: walk runs out of address
        send_request(REQ_WR_SUB, '0, '0, 20'hFFFFF, 1'b1, 16'hFFFF, 1'b1, 12'hFFF);
        send_request(REQ_LOOKUP, '1, '1, '0, 1'b0, '0, 1'b0, '0);
        send_request(REQ_WR_SUB, '1, '1, 20'h00000, 1'b0, 16'h0000, 1'b0, 12'h000);
    endtask

    // Full-depth chain with some invalid hops on the way
    task automatic test_deep_chain();
        logic [127:0] chain_addr;
        logic [127:0] probe;
        logic [11:0]  node;
        chain_addr = {16'h2001, 112'h0db8_85a3_0000_0000_8a2e_0370_7334};
        send_request(REQ_WR_ROOT, '0, '0, {4'd0, chain_addr[127:112]}, 1'b1, 16'h0001,
                     1'b1, 12'hFFF);
        for (int k = 0; k < 14; k++)
        begin
            node = (k == 0) ? 12'hFFF : 12'(k);
            send_request(REQ_WR_SUB, '0, '0, {node, chain_addr[111 - 8 * k -: 8]},
                         (k % 3 != 1), 16'h1000 + 16'(k), 1'b1, 12'(k + 1));
        end
        send_request(REQ_LOOKUP, chain_addr[127:64], chain_addr[63:0], '0, 1'b0, '0,
                     1'b0, '0);
        probe = chain_addr ^ 128'hFF;
        send_request(REQ_LOOKUP, probe[127:64], probe[63:0], '0, 1'b0, '0, 1'b0, '0);
        probe = chain_addr ^ {48'd0, 8'hFF, 72'd0};
        send_request(REQ_LOOKUP, probe[127:64], probe[63:0], '0, 1'b0, '0, 1'b0, '0);
    endtask

    // Back-to-back stretch with no stalls on either side
    task automatic test_back_to_back(input int count);
        allow_idle = 1'b0;
        repeat (count)
            random_request();
        allow_idle = 1'b1;
    endtask

    // Bulk random traffic with stalls on both sides
    task automatic test_random_traffic(input int count);
        repeat (count)
            random_request();
    endtask

    // Result checker
    always @(posedge clk)
    begin
        cycle_count++;
        if (m_tvalid && m_tready)
        begin
            if (awaited_routes.size() == 0)
                report_mismatch("result with no request outstanding",
                                {7'd0, m_tuser, m_tdata}, '0);
            else
            begin
                want_route = awaited_routes.pop_front();
                if (m_tdata[15:0] !== want_route.hop)
                    report_mismatch("found_hop", 32'(m_tdata[15:0]),
                                    32'(want_route.hop));
                if (m_tdata[19:16] !== want_route.depth)
                    report_mismatch("levels_used", 32'(m_tdata[19:16]),
                                    32'(want_route.depth));
                if (m_tdata[23:20] !== 4'd0)
                    report_mismatch("tdata padding", 32'(m_tdata[23:20]), '0);
                if (m_tuser !== want_route.write_ack)
                    report_mismatch("is_write_ack", 32'(m_tuser),
                                    32'(want_route.write_ack));
            end
            results_seen++;
        end
    end

    // Test sequence
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_LOOKUP;
        allow_idle  = 1'b1;
        mismatches  = 0;
        results_seen = 0;
        cycle_count = 0;
        prefix_picks[0] = 16'h0000;
        prefix_picks[1] = 16'hFFFF;
        for (int k = 2; k < 6; k++)
            prefix_picks[k] = 16'($urandom());
        byte_picks[0] = 8'h00;
        byte_picks[1] = 8'hFF;
        byte_picks[2] = 8'($urandom());
        byte_picks[3] = 8'($urandom());

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_empty_tables();
        test_field_extremes();
        test_deep_chain();
        test_back_to_back(300);
        test_random_traffic(1500);

        @(negedge clk);
        s_tvalid = 1'b0;
        while (awaited_routes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
